[hdl/bmpw_pkg.sv]
// ----------------------------------------------------------------------------
// bmpw_pkg
// Types, register indexes and fixed-point constants of the beam model
// particle weight block.
// ----------------------------------------------------------------------------
package bmpw_pkg;

   typedef struct packed {
      logic [15:0] measured_range;
      logic [15:0] expected_range;
      logic        ray_ok;
      logic        last_ray;
      logic [31:0] prior_weight;
   } req_type;

   typedef struct packed {
      logic [23:0] score;
      logic [31:0] new_weight;
   } rsp_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_WEIGHT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_WEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WEIGHT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAND_LEVEL    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_EXP_SCALE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_DECAY   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RANGE     = 3'd6;

   localparam logic [15:0] RST_HIT_WEIGHT    = 16'd52429;
   localparam logic [15:0] RST_SHORT_WEIGHT  = 16'd6554;
   localparam logic [15:0] RST_MAX_WEIGHT    = 16'd3277;
   localparam logic [15:0] RST_RAND_LEVEL    = 16'd109;
   localparam logic [31:0] RST_HIT_EXP_SCALE = 32'd95444;
   localparam logic [31:0] RST_SHORT_DECAY   = 32'd42950;
   localparam logic [15:0] RST_MAX_RANGE     = 16'd30000;

   localparam logic [23:0] ONE_Q16  = 24'd65536;
   localparam logic [23:0] SUM_MAX  = 24'hFFFFFF;
   localparam logic [18:0] MIX_CAP  = 19'd458752;
   localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
   localparam int          SER_TERMS = 20;

   // Twenty-term series of e^u in Q2.30, evaluated at elaboration only.
   function automatic logic [63:0] exp_series_f(input logic [63:0] u);
      logic [63:0] acc;
      logic [63:0] term;
      acc  = 64'(ONE_Q30);
      term = 64'(ONE_Q30);
      for (int k = 1; k <= SER_TERMS; k++) begin
         term = ((term * u) >> 30) / 64'(k);
         acc  = acc + term;
      end
      return acc;
   endfunction

   // Series terms are divided by their index k through a rounded-up
   // reciprocal scaled by 2^(30 + ceil(log2 k)). Since every dividend stays
   // below 2^30, the product shifted right by that amount is the exact floor.
   function automatic logic [SER_TERMS:1][2:0] k_shift_f();
      logic [SER_TERMS:1][2:0] t;
      int                      c;
      for (int k = 1; k <= SER_TERMS; k++) begin
         c = 0;
         while ((1 << c) < k) c++;
         t[k] = 3'(c);
      end
      return t;
   endfunction

   function automatic logic [SER_TERMS:1][31:0] k_recip_f();
      logic [SER_TERMS:1][31:0] t;
      int                       c;
      for (int k = 1; k <= SER_TERMS; k++) begin
         c = 0;
         while ((1 << c) < k) c++;
         t[k] = 32'(((64'd1 << (30 + c)) + 64'(k - 1)) / 64'(k));
      end
      return t;
   endfunction

   localparam logic [SER_TERMS:1][2:0]  K_SHIFT = k_shift_f();
   localparam logic [SER_TERMS:1][31:0] K_RECIP = k_recip_f();

   localparam logic [63:0] E_WIDE     = exp_series_f(64'(ONE_Q30));
   localparam logic [63:0] INV_E_WIDE = (64'd1 << 60) / E_WIDE;
   localparam logic [31:0] E_Q30      = E_WIDE[31:0];
   localparam logic [31:0] INV_E_Q30  = INV_E_WIDE[31:0];

endpackage

[hdl/beam_model_particle_weight.sv]
// ----------------------------------------------------------------------------
// beam_model_particle_weight
// Scores one particle against a laser scan, one ray per word, with the beam
// mixture model; emits the likelihood sum and the updated weight on the
// last ray of a particle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | req_data (req_type)
//  rsp     | out       | rsp_valid/ready   | rsp_data (rsp_type)
//  csr     | in        | csr_we            | csr_index, csr_wdata
//
// An invalid ray goes straight to the cube of its mixture value. For a valid
// ray, each series term of an exponential runs a product, a multiplication by
// the reciprocal of the term index and a sum, and the hit term adds a radix-2
// divide for the reciprocal. A last ray adds a weight product and an emit
// step; reset is synchronous and sets the sum to 1.0.
// A last-ray word waits in its emit step while the previous result is unread.
// ----------------------------------------------------------------------------
module beam_model_particle_weight
   import bmpw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_HSQ    = 5'd1;
   localparam logic [4:0] ST_HSC    = 5'd2;
   localparam logic [4:0] ST_HCHK   = 5'd3;
   localparam logic [4:0] ST_SMUL   = 5'd4;
   localparam logic [4:0] ST_SCHK   = 5'd5;
   localparam logic [4:0] ST_SERMUL = 5'd6;
   localparam logic [4:0] ST_SERLD  = 5'd7;
   localparam logic [4:0] ST_DIV    = 5'd8;
   localparam logic [4:0] ST_DDONE  = 5'd9;
   localparam logic [4:0] ST_CTEST  = 5'd10;
   localparam logic [4:0] ST_MLO    = 5'd11;
   localparam logic [4:0] ST_MHI    = 5'd12;
   localparam logic [4:0] ST_MSUM   = 5'd13;
   localparam logic [4:0] ST_MIX    = 5'd14;
   localparam logic [4:0] ST_CSQ    = 5'd15;
   localparam logic [4:0] ST_CLO    = 5'd16;
   localparam logic [4:0] ST_CHI    = 5'd17;
   localparam logic [4:0] ST_CSUM   = 5'd18;
   localparam logic [4:0] ST_WMUL   = 5'd19;
   localparam logic [4:0] ST_EMIT   = 5'd20;

   logic [4:0]  state_ff, state_in;
   logic [15:0] hit_w_ff, short_w_ff, max_w_ff, rand_l_ff, max_r_ff;
   logic [31:0] hexp_ff, sdecay_ff;
   logic [15:0] meas_ff, meas_in, expd_ff, expd_in;
   logic        last_ff, last_in;
   logic [31:0] prior_ff, prior_in;
   logic [23:0] sum_ff, sum_in;
   logic [19:0] p_ff, p_in;
   logic [3:0]  n_ff, n_in;
   logic [29:0] f_ff, f_in;
   logic [30:0] term_ff, term_in;
   logic [31:0] acc_ff, acc_in;
   logic [4:0]  k_ff, k_in;
   logic [50:0] x_ff, x_in;
   logic [31:0] mb_ff, mb_in;
   logic        fin_ff, fin_in;
   logic        sel_short_ff, sel_short_in;
   logic [37:0] tmp_ff, tmp_in;
   logic [18:0] sq_hi_ff, sq_hi_in;
   logic [31:0] div_rem_ff, div_rem_in, div_lo_ff, div_lo_in;
   logic [31:0] div_q_ff, div_q_in, div_d_ff, div_d_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic        div_inv_ff, div_inv_in;
   logic [63:0] prod_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0] mul_a, mul_b;
   logic [15:0] dz, sdiff;
   logic [32:0] div_t, div_sub;
   logic        div_ge;
   logic [31:0] ser_q;
   logic [31:0] acc_next;
   logic [52:0] m30_sum;
   logic [20:0] mix_sum;
   logic [57:0] cube_wide;
   logic [26:0] sum_wide;
   logic [23:0] sum_sat;
   logic [31:0] w_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dz    = (meas_ff >= expd_ff) ? (meas_ff - expd_ff) : (expd_ff - meas_ff);
   assign sdiff = expd_ff - meas_ff;

   // One restoring division step per cycle.
   assign div_t    = {div_rem_ff, div_lo_ff[31]};
   assign div_sub  = div_t - {1'b0, div_d_ff};
   assign div_ge   = (div_t >= {1'b0, div_d_ff});

   // Series term over k, taken from the reciprocal product.
   assign ser_q    = 32'(prod_ff >> (6'd30 + 6'(K_SHIFT[k_ff])));
   assign acc_next = acc_ff + ser_q;

   assign m30_sum   = prod_ff[52:0] + 53'(tmp_ff[31:0]);
   assign mix_sum   = 21'(p_ff) + 21'((meas_ff >= max_r_ff) ? max_w_ff : rand_l_ff);
   assign cube_wide = {prod_ff[37:0], 19'b0} + 58'(tmp_ff);
   assign sum_wide  = 27'(sum_ff) + 27'(cube_wide[57:32]);
   assign sum_sat   = (sum_wide > 27'(SUM_MAX)) ? SUM_MAX : sum_wide[23:0];
   assign w_sat     = (prod_ff[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod_ff[47:16];

   always_comb begin
      mul_a = prior_ff;
      mul_b = 32'(sum_ff);
      case (state_ff)
         ST_HSQ: begin
            mul_a = 32'(dz);
            mul_b = 32'(dz);
         end
         ST_HSC: begin
            mul_a = prod_ff[31:0];
            mul_b = hexp_ff;
         end
         ST_SMUL: begin
            mul_a = 32'(sdiff);
            mul_b = sdecay_ff;
         end
         ST_SERMUL: begin
            mul_a = 32'(term_ff);
            mul_b = 32'(f_ff);
         end
         ST_SERLD: begin
            mul_a = prod_ff[61:30];
            mul_b = K_RECIP[k_ff];
         end
         ST_MLO: begin
            mul_a = 32'(x_ff[29:0]);
            mul_b = mb_ff;
         end
         ST_MHI: begin
            mul_a = 32'(x_ff[50:30]);
            mul_b = mb_ff;
         end
         ST_CSQ: begin
            mul_a = 32'(p_ff[18:0]);
            mul_b = 32'(p_ff[18:0]);
         end
         ST_CLO: begin
            mul_a = 32'(prod_ff[18:0]);
            mul_b = 32'(p_ff[18:0]);
         end
         ST_CHI: begin
            mul_a = 32'(sq_hi_ff);
            mul_b = 32'(p_ff[18:0]);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      expd_in      = expd_ff;
      last_in      = last_ff;
      prior_in     = prior_ff;
      sum_in       = sum_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      f_in         = f_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      mb_in        = mb_ff;
      fin_in       = fin_ff;
      sel_short_in = sel_short_ff;
      tmp_in       = tmp_ff;
      sq_hi_in     = sq_hi_ff;
      div_rem_in   = div_rem_ff;
      div_lo_in    = div_lo_ff;
      div_q_in     = div_q_ff;
      div_d_in     = div_d_ff;
      div_cnt_in   = div_cnt_ff;
      div_inv_in   = div_inv_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in  = req_data.measured_range;
               expd_in  = req_data.expected_range;
               last_in  = req_data.last_ray;
               prior_in = req_data.prior_weight;
               if (req_data.ray_ok) begin
                  p_in     = 20'd0;
                  state_in = ST_HSQ;
               end else begin
                  p_in     = 20'(max_w_ff);
                  state_in = ST_CSQ;
               end
            end
         end
         ST_HSQ: state_in = ST_HSC;
         ST_HSC: state_in = ST_HCHK;
         ST_HCHK: begin
            // An integer part of sixteen or more makes the hit term vanish.
            if (prod_ff[63:36] != 28'd0) begin
               state_in = ST_SMUL;
            end else begin
               n_in         = prod_ff[35:32];
               f_in         = prod_ff[31:2];
               term_in      = ONE_Q30[30:0];
               acc_in       = ONE_Q30;
               k_in         = 5'd1;
               sel_short_in = 1'b0;
               state_in     = ST_SERMUL;
            end
         end
         ST_SMUL: begin
            if (meas_ff > expd_ff) state_in = ST_MIX;
            else state_in = ST_SCHK;
         end
         ST_SCHK: begin
            if ((prod_ff[63:36] != 28'd0) || (prod_ff[35:32] >= 4'd14)) begin
               p_in     = p_ff + ((short_w_ff != 16'd0) ? 20'(MIX_CAP) : 20'd0);
               state_in = ST_MIX;
            end else begin
               n_in         = prod_ff[35:32];
               f_in         = prod_ff[31:2];
               term_in      = ONE_Q30[30:0];
               acc_in       = ONE_Q30;
               k_in         = 5'd1;
               sel_short_in = 1'b1;
               state_in     = ST_SERMUL;
            end
         end
         ST_SERMUL: state_in = ST_SERLD;
         ST_SERLD: begin
            div_inv_in = 1'b0;
            state_in   = ST_DDONE;
         end
         ST_DIV: begin
            div_rem_in = div_ge ? div_sub[31:0] : div_t[31:0];
            div_lo_in  = {div_lo_ff[30:0], 1'b0};
            div_q_in   = {div_q_ff[30:0], div_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) state_in = ST_DDONE;
         end
         ST_DDONE: begin
            if (div_inv_ff) begin
               x_in     = 51'(div_q_ff);
               state_in = ST_CTEST;
            end else begin
               term_in = ser_q[30:0];
               acc_in  = acc_next;
               if ((ser_q == 32'd0) || (k_ff == 5'(SER_TERMS))) begin
                  if (sel_short_ff) begin
                     x_in     = 51'(acc_next);
                     state_in = ST_CTEST;
                  end else begin
                     // Reciprocal of the series: 2^60 over the sum.
                     div_rem_in = 32'h1000_0000;
                     div_lo_in  = 32'd0;
                     div_d_in   = acc_next;
                     div_cnt_in = 5'd0;
                     div_inv_in = 1'b1;
                     state_in   = ST_DIV;
                  end
               end else begin
                  k_in     = k_ff + 5'd1;
                  state_in = ST_SERMUL;
               end
            end
         end
         ST_CTEST: begin
            if (n_ff != 4'd0) begin
               mb_in  = sel_short_ff ? E_Q30 : INV_E_Q30;
               n_in   = n_ff - 4'd1;
               fin_in = 1'b0;
            end else begin
               mb_in  = 32'(sel_short_ff ? short_w_ff : hit_w_ff);
               fin_in = 1'b1;
            end
            state_in = ST_MLO;
         end
         ST_MLO: state_in = ST_MHI;
         ST_MHI: begin
            tmp_in   = 38'(prod_ff[61:30]);
            state_in = ST_MSUM;
         end
         ST_MSUM: begin
            if (!fin_ff) begin
               x_in     = m30_sum[50:0];
               state_in = ST_CTEST;
            end else if (sel_short_ff) begin
               p_in = p_ff + ((m30_sum > 53'(MIX_CAP)) ? 20'(MIX_CAP) : m30_sum[19:0]);
               state_in = ST_MIX;
            end else begin
               p_in     = p_ff + 20'(m30_sum[16:0]);
               state_in = ST_SMUL;
            end
         end
         ST_MIX: begin
            p_in     = (mix_sum > 21'(MIX_CAP)) ? 20'(MIX_CAP) : mix_sum[19:0];
            state_in = ST_CSQ;
         end
         ST_CSQ: state_in = ST_CLO;
         ST_CLO: begin
            sq_hi_in = prod_ff[37:19];
            state_in = ST_CHI;
         end
         ST_CHI: begin
            tmp_in   = prod_ff[37:0];
            state_in = ST_CSUM;
         end
         ST_CSUM: begin
            sum_in   = sum_sat;
            state_in = last_ff ? ST_WMUL : ST_IDLE;
         end
         ST_WMUL: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.score      = sum_ff;
               rsp_data_in.new_weight = w_sat;
               sum_in                 = ONE_Q16;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= ONE_Q16;
         rsp_valid_ff <= 1'b0;
         hit_w_ff     <= RST_HIT_WEIGHT;
         short_w_ff   <= RST_SHORT_WEIGHT;
         max_w_ff     <= RST_MAX_WEIGHT;
         rand_l_ff    <= RST_RAND_LEVEL;
         hexp_ff      <= RST_HIT_EXP_SCALE;
         sdecay_ff    <= RST_SHORT_DECAY;
         max_r_ff     <= RST_MAX_RANGE;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HIT_WEIGHT:    hit_w_ff   <= csr_wdata[15:0];
               CSR_SHORT_WEIGHT:  short_w_ff <= csr_wdata[15:0];
               CSR_MAX_WEIGHT:    max_w_ff   <= csr_wdata[15:0];
               CSR_RAND_LEVEL:    rand_l_ff  <= csr_wdata[15:0];
               CSR_HIT_EXP_SCALE: hexp_ff    <= csr_wdata;
               CSR_SHORT_DECAY:   sdecay_ff  <= csr_wdata;
               CSR_MAX_RANGE:     max_r_ff   <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      meas_ff      <= meas_in;
      expd_ff      <= expd_in;
      last_ff      <= last_in;
      prior_ff     <= prior_in;
      p_ff         <= p_in;
      n_ff         <= n_in;
      f_ff         <= f_in;
      term_ff      <= term_in;
      acc_ff       <= acc_in;
      k_ff         <= k_in;
      x_ff         <= x_in;
      mb_ff        <= mb_in;
      fin_ff       <= fin_in;
      sel_short_ff <= sel_short_in;
      tmp_ff       <= tmp_in;
      sq_hi_ff     <= sq_hi_in;
      div_rem_ff   <= div_rem_in;
      div_lo_ff    <= div_lo_in;
      div_q_ff     <= div_q_in;
      div_d_ff     <= div_d_in;
      div_cnt_ff   <= div_cnt_in;
      div_inv_ff   <= div_inv_in;
      prod_ff      <= 64'(mul_a) * 64'(mul_b);
      rsp_data_ff  <= rsp_data_in;
   end

   a_sum_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) |=> sum_ff == ONE_Q16)
      else $error("running sum not restarted after emit");

   a_mix_capped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CSQ) |-> p_ff <= 20'(MIX_CAP))
      else $error("mixture value above cap at cube");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> div_rem_ff < div_d_ff)
      else $error("divider remainder not below divisor");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");

endmodule
